// File: hdl/mko_pkg.sv
// Shared constants, operation codes and helper functions for the mecanum kinematics unit.
`default_nettype none
package mko_pkg;

  localparam int unsigned InW      = 240;  // seven 32-bit fields and one 16-bit field
  localparam int unsigned OutW     = 320;  // ten 32-bit fields
  localparam int unsigned CfgW     = 31;
  localparam int unsigned AtanSize = 30;

  localparam logic [33:0] CordicStart = 34'd652032874;
  localparam logic [29:0] RadToBam    = 30'd683565276;

  // register indexes
  localparam logic [1:0] REG_HALF_AXIS     = 2'd0;
  localparam logic [1:0] REG_INV_HALF_AXIS = 2'd1;
  localparam logic [1:0] REG_WHEEL_RADIUS  = 2'd2;
  localparam logic [1:0] REG_INV_WHEEL_RAD = 2'd3;

  // multiply operation codes, in issue order
  localparam logic [4:0] OP_RW     = 5'd0;
  localparam logic [4:0] OP_TFL    = 5'd1;
  localparam logic [4:0] OP_TFR    = 5'd2;
  localparam logic [4:0] OP_TBL    = 5'd3;
  localparam logic [4:0] OP_TBR    = 5'd4;
  localparam logic [4:0] OP_BVX    = 5'd5;
  localparam logic [4:0] OP_BVY    = 5'd6;
  localparam logic [4:0] OP_WR     = 5'd7;
  localparam logic [4:0] OP_BWZ    = 5'd8;
  localparam logic [4:0] OP_XC     = 5'd9;
  localparam logic [4:0] OP_YS     = 5'd10;
  localparam logic [4:0] OP_XS     = 5'd11;
  localparam logic [4:0] OP_YC     = 5'd12;
  localparam logic [4:0] OP_PX     = 5'd13;
  localparam logic [4:0] OP_PY     = 5'd14;
  localparam logic [4:0] OP_WDT    = 5'd15;
  localparam logic [4:0] OP_HEAD   = 5'd16;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mecanum_kinematics_odometry_unit.sv
// Top level: mecanum inverse/forward kinematics and pose odometry on one shared multiplier.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | command, wheel speeds, tick length
//  m_axis    | out       | m_axis_tvalid/tready       | wheel targets, body velocity, pose
//  cfg       | in        | cfg_we_i                   | geometry registers, write only
//
//  One transfer takes 9 multiply operations and a finishing step when the tick length is
//  zero; otherwise 17 operations, CORDIC_STEPS CORDIC iterations (at most 30) and the
//  finishing step. Each operation loads its operands, applies the 16x32 multiplier three
//  times and writes the result back.
//  s_axis_tready is high only while the sequencer is idle; a result waits in its output
//  register while the next transfer is taken, and the sequencer holds at completion only
//  if that register is still full. Reset clears pose and handshake state, presets geometry.
`default_nettype none
module mecanum_kinematics_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  // cmd_vx, cmd_vy, cmd_wz, wheel_fl_speed, wheel_fr_speed, wheel_bl_speed,
  // wheel_br_speed, tick_seconds
  input  wire  [mko_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  // target_fl, target_fr, target_bl, target_br, body_vx, body_vy, body_wz,
  // pose_x, pose_y, pose_heading
  output logic [mko_pkg::OutW-1:0] m_axis_tdata,
  input  wire                      cfg_we_i,
  input  wire  [1:0]               cfg_idx_i,
  input  wire  [mko_pkg::CfgW-1:0] cfg_data_i
);
  import mko_pkg::*;

  localparam int unsigned NIter = (CORDIC_STEPS < AtanSize) ? CORDIC_STEPS : AtanSize;
  localparam logic [4:0]  LastIter = 5'(NIter - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_WB     = 3'd3;
  localparam logic [2:0] S_CORDIC = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [4:0]  op_q, op_d;
  logic [1:0]  ph_q, ph_d;
  logic [4:0]  it_q, it_d;

  logic [30:0] half_q, inv_half_q, rad_q, inv_rad_q;
  logic [InW-1:0] in_q;

  // multiplier operands and accumulator
  logic [46:0] mag_a_q;
  logic [31:0] mag_b_q;
  logic        neg_q, k2_q;
  logic [78:0] acc_q, acc_d;

  // intermediate results
  logic signed [47:0] rw_q, tmp_q;
  logic signed [48:0] dx_q, dy_q;
  logic [31:0] tfl_q, tfr_q, tbl_q, tbr_q, bvx_q, bvy_q, bwz_q;
  logic [31:0] px_q, py_q, head_q;

  // CORDIC datapath
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [19:0] cos_q, sin_q;
  logic signed [19:0] cos_n, sin_n;

  logic               out_valid_q;
  logic [OutW-1:0]    out_q;

  // unpacked input fields
  logic signed [49:0] vx, vy, wz, fl, fr, bl, br, rw50;
  logic [15:0]        dt;
  assign vx = 50'($signed(in_q[31:0]));
  assign vy = 50'($signed(in_q[63:32]));
  assign wz = 50'($signed(in_q[95:64]));
  assign fl = 50'($signed(in_q[127:96]));
  assign fr = 50'($signed(in_q[159:128]));
  assign bl = 50'($signed(in_q[191:160]));
  assign br = 50'($signed(in_q[223:192]));
  assign dt = in_q[239:224];
  assign rw50 = 50'(rw_q);

  // operand selection for the shared multiplier
  logic signed [49:0] op_a;
  logic signed [32:0] op_b;
  logic               op_k2;
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_k2 = 1'b0;
    case (op_q)
      OP_RW:  begin op_a = 50'($signed({1'b0, half_q})); op_b = 33'(wz); end
      OP_TFL: begin op_a = vx - vy - rw50; op_b = {2'b0, inv_rad_q}; end
      OP_TFR: begin op_a = vx + vy + rw50; op_b = {2'b0, inv_rad_q}; end
      OP_TBL: begin op_a = vx + vy - rw50; op_b = {2'b0, inv_rad_q}; end
      OP_TBR: begin op_a = vx - vy + rw50; op_b = {2'b0, inv_rad_q}; end
      OP_BVX: begin op_a = fl + fr + bl + br; op_b = {2'b0, rad_q}; op_k2 = 1'b1; end
      OP_BVY: begin op_a = fr + bl - fl - br; op_b = {2'b0, rad_q}; op_k2 = 1'b1; end
      OP_WR:  begin op_a = fr + br - fl - bl; op_b = {2'b0, rad_q}; end
      OP_BWZ: begin op_a = 50'(tmp_q); op_b = {2'b0, inv_half_q}; op_k2 = 1'b1; end
      OP_XC:  begin op_a = 50'($signed(bvx_q)); op_b = 33'(cos_n); end
      OP_YS:  begin op_a = 50'($signed(bvy_q)); op_b = 33'(sin_q); end
      OP_XS:  begin op_a = 50'($signed(bvx_q)); op_b = 33'(sin_q); end
      OP_YC:  begin op_a = 50'($signed(bvy_q)); op_b = 33'(cos_q); end
      OP_PX:  begin op_a = 50'(dx_q); op_b = {17'b0, dt}; end
      OP_PY:  begin op_a = 50'(dy_q); op_b = {17'b0, dt}; end
      OP_WDT: begin op_a = 50'($signed(bwz_q)); op_b = {17'b0, dt}; end
      OP_HEAD: begin op_a = 50'(tmp_q); op_b = {3'b0, RadToBam}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // sign-magnitude split, magnitude of a clamped to 2^47-1
  logic [49:0] abs_a;
  logic [32:0] abs_b;
  assign abs_a = op_a[49] ? 50'(-op_a) : 50'(op_a);
  assign abs_b = op_b[32] ? 33'(-op_b) : 33'(op_b);

  // one 16x32 partial product per cycle
  logic [15:0] chunk;
  logic [47:0] prod;
  always_comb begin
    case (ph_q)
      2'd0:    chunk = mag_a_q[15:0];
      2'd1:    chunk = mag_a_q[31:16];
      default: chunk = {1'b0, mag_a_q[46:32]};
    endcase
  end
  assign prod = chunk * mag_b_q;

  always_comb begin
    case (ph_q)
      2'd0:    acc_d = acc_q + {31'b0, prod};
      2'd1:    acc_d = acc_q + {15'b0, prod, 16'b0};
      default: acc_d = acc_q + {prod[46:0], 32'b0};
    endcase
  end

  // scale, clamp and restore sign
  logic [62:0] sh;
  logic [46:0] rmag;
  logic signed [47:0] res;
  assign sh   = k2_q ? {2'b0, acc_q[78:18]} : acc_q[78:16];
  assign rmag = (|sh[62:47]) ? {47{1'b1}} : sh[46:0];
  assign res  = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

  logic signed [49:0] res50;
  assign res50 = 50'(res);

  // CORDIC micro-rotation
  logic signed [33:0] xs, ys, at;
  assign xs = cx_q >>> it_q;
  assign ys = cy_q >>> it_q;
  assign at = $signed({4'b0, atan_bam(it_q)});

  // start angle with left half plane folded over
  logic [31:0] ang_t;
  logic        flip_n;
  assign ang_t  = head_q + 32'h4000_0000;
  assign flip_n = ang_t[31];

  logic signed [33:0] cx_sh, cy_sh;
  assign cx_sh = cx_q >>> 14;
  assign cy_sh = cy_q >>> 14;

  // signed Q4.16 cosine and sine of the settled rotation, sign restored
  assign cos_n = flip_q ? 20'(-cx_sh) : 20'(cx_sh);
  assign sin_n = flip_q ? 20'(-cy_sh) : 20'(cy_sh);

  logic finish;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ph_d    = ph_q;
    it_d    = it_q;
    finish  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_LOAD;
          op_d    = OP_RW;
        end
      end
      S_LOAD: begin
        state_d = S_MUL;
        ph_d    = 2'd0;
      end
      S_MUL: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (op_q == OP_BWZ) begin
          if (dt == 16'd0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_CORDIC;
            it_d    = 5'd0;
          end
        end else if (op_q == OP_HEAD) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LOAD;
          op_d    = op_q + 5'd1;
        end
      end
      S_CORDIC: begin
        it_d = it_q + 5'd1;
        if (it_q == LastIter) begin
          state_d = S_LOAD;
          op_d    = OP_XC;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_RW;
      ph_q        <= 2'd0;
      it_q        <= 5'd0;
      out_valid_q <= 1'b0;
      half_q      <= 31'd26214;
      inv_half_q  <= 31'd163840;
      rad_q       <= 31'd4588;
      inv_rad_q   <= 31'd936229;
      px_q        <= '0;
      py_q        <= '0;
      head_q      <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ph_q    <= ph_d;
      it_q    <= it_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HALF_AXIS:     half_q     <= cfg_data_i;
          REG_INV_HALF_AXIS: inv_half_q <= cfg_data_i;
          REG_WHEEL_RADIUS:  rad_q      <= cfg_data_i;
          REG_INV_WHEEL_RAD: inv_rad_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // pose state advances only on the pose write-back operations
      if (state_q == S_WB) begin
        case (op_q)
          OP_PX:   px_q   <= sat32(50'($signed(px_q)) + res50);
          OP_PY:   py_q   <= sat32(50'($signed(py_q)) + res50);
          OP_HEAD: head_q <= head_q + res[31:0];
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
    if (state_q == S_LOAD) begin
      mag_a_q <= (|abs_a[49:47]) ? {47{1'b1}} : abs_a[46:0];
      mag_b_q <= abs_b[31:0];
      neg_q   <= op_a[49] ^ op_b[32];
      k2_q    <= op_k2;
      acc_q   <= '0;
    end else if (state_q == S_MUL) begin
      acc_q <= acc_d;
    end
    if (state_q == S_WB) begin
      case (op_q)
        OP_RW:  rw_q  <= res;
        OP_TFL: tfl_q <= sat32(res50);
        OP_TFR: tfr_q <= sat32(res50);
        OP_TBL: tbl_q <= sat32(res50);
        OP_TBR: tbr_q <= sat32(res50);
        OP_BVX: bvx_q <= sat32(res50);
        OP_BVY: bvy_q <= sat32(res50);
        OP_WR:  tmp_q <= res;
        OP_BWZ: bwz_q <= sat32(res50);
        OP_XC:  dx_q  <= 49'(res);
        OP_YS:  dx_q  <= dx_q - 49'(res);
        OP_XS:  dy_q  <= 49'(res);
        OP_YC:  dy_q  <= dy_q + 49'(res);
        OP_WDT: tmp_q <= res;
        default: ;
      endcase
      if (op_q == OP_BWZ) begin
        cx_q   <= $signed(CordicStart);
        cy_q   <= '0;
        cz_q   <= flip_n ? 34'($signed(head_q + 32'h8000_0000)) : 34'($signed(head_q));
        flip_q <= flip_n;
      end
    end
    if (state_q == S_CORDIC) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (state_q == S_LOAD && op_q == OP_XC) begin
      // hold the scaled results once the last rotation has settled
      cos_q <= cos_n;
      sin_q <= sin_n;
    end
    if (finish) begin
      out_q <= {head_q, py_q, px_q, bwz_q, bvy_q, bvx_q, tbr_q, tbl_q, tfr_q, tfl_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// File: hdl/mko_checker.sv
// Port-level checker for the mecanum kinematics unit, bound to the top level.
`default_nettype none
module mko_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [319:0] m_axis_tdata
);

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an accepted transfer makes the unit busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a transfer");

  // ready drops only because a transfer was taken
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("ready fell without a transfer");

  // an accepted transfer keeps the unit busy into its first multiply operation
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##3 !s_axis_tready)
    else $error("transfer finished too early");

endmodule

bind mecanum_kinematics_odometry_unit mko_checker u_mko_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
